// ===== hw/rtl/double_ended_queue_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

    // default number of slots
    localparam int DEQ_DEPTH = 256;

    // field widths
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int IN_W     = ((MODE_W + VALUE_W + 7) / 8) * 8;

    // request codes
    localparam logic [MODE_W-1:0] MODE_PUSH_TOP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BOTTOM = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_TOP     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BOTTOM  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REVERSE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY       = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // handshake sequencer
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_deq_state;

endpackage

// ===== hw/rtl/deq_ram.sv =====
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, two registered read ports (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== hw/rtl/deq_core.sv =====
module deq_core #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH,
    localparam int CW   = $clog2(DEPTH + 1),
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [deq_pkg::MODE_W-1:0]    i_mode,
    input  logic [deq_pkg::VALUE_W-1:0]   i_value,
    output logic [deq_pkg::VALUE_W-1:0]   o_top,
    output logic [deq_pkg::VALUE_W-1:0]   o_bottom,
    output logic [CW-1:0]                 o_count,
    output logic [deq_pkg::STATUS_W-1:0]  o_status
);

    import deq_pkg::*;

    // pointer state
    logic [AW-1:0]       r_front, n_front;
    logic [CW-1:0]       r_count, n_count;
    logic                r_rev, n_rev;
    logic [STATUS_W-1:0] r_status, n_status;

    // write-to-read forwarding
    logic                r_fwd_hi, r_fwd_lo;
    logic [VALUE_W-1:0]  r_fwd_data;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic                w_full, w_empty, w_top_is_high;
    logic [CW:0]         w_end_sum, w_hi_sum;
    logic [AW-1:0]       w_end_slot, w_hi_addr;
    logic [AW-1:0]       w_front_dec, w_front_inc;
    logic [VALUE_W-1:0]  w_rd_hi, w_rd_lo, w_hi_val, w_lo_val;

    assign w_full        = (r_count == CW'(DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_top_is_high = !r_rev;

    // slot just past the high end, wrapped
    assign w_end_sum  = (CW+1)'(r_front) + (CW+1)'(r_count);
    assign w_end_slot = (w_end_sum >= (CW+1)'(DEPTH)) ?
                        AW'(w_end_sum - (CW+1)'(DEPTH)) : AW'(w_end_sum);

    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign w_front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    // request decode and pointer update
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = w_end_slot;
        if (i_accept) begin
            n_status = STATUS_DONE;
            case (i_mode)
                MODE_PUSH_TOP, MODE_PUSH_BOTTOM: begin
                    if (w_full) begin
                        n_status = STATUS_FULL;
                    end else if ((i_mode == MODE_PUSH_TOP) == w_top_is_high) begin
                        w_we    = 1'b1;
                        w_waddr = w_end_slot;
                        n_count = r_count + 1'b1;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_front_dec;
                        n_front = w_front_dec;
                        n_count = r_count + 1'b1;
                    end
                end
                MODE_POP_TOP, MODE_POP_BOTTOM: begin
                    if (w_empty) begin
                        n_status = STATUS_EMPTY;
                    end else if ((i_mode == MODE_POP_TOP) == w_top_is_high) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_front = w_front_inc;
                        n_count = r_count - 1'b1;
                    end
                end
                MODE_REVERSE: begin
                    n_rev = !r_rev;
                end
                default: begin
                    // query and unused codes
                    if (w_empty) begin
                        n_status = STATUS_EMPTY;
                    end
                end
            endcase
        end
    end

    // read both ends of the updated region; garbage when it is empty
    assign w_hi_sum  = (CW+1)'(n_front) + (CW+1)'(n_count) - 1'b1;
    assign w_hi_addr = (w_hi_sum >= (CW+1)'(DEPTH)) ?
                       AW'(w_hi_sum - (CW+1)'(DEPTH)) : AW'(w_hi_sum);

    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (i_value),
        .i_raddr_a (w_hi_addr),
        .i_raddr_b (n_front),
        .o_rdata_a (w_rd_hi),
        .o_rdata_b (w_rd_lo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_rev    <= 1'b0;
            r_status <= STATUS_DONE;
            r_fwd_hi <= 1'b0;
            r_fwd_lo <= 1'b0;
        end else begin
            r_front  <= n_front;
            r_count  <= n_count;
            r_rev    <= n_rev;
            r_status <= n_status;
            r_fwd_hi <= w_we && (w_waddr == w_hi_addr);
            r_fwd_lo <= w_we && (w_waddr == n_front);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_value;
    end

    // map physical ends to top and bottom
    assign w_hi_val = r_fwd_hi ? r_fwd_data : w_rd_hi;
    assign w_lo_val = r_fwd_lo ? r_fwd_data : w_rd_lo;

    always_comb begin
        o_top    = '0;
        o_bottom = '0;
        if (!w_empty) begin
            o_top    = r_rev ? w_lo_val : w_hi_val;
            o_bottom = r_rev ? w_hi_val : w_lo_val;
        end
    end

    assign o_count  = r_count;
    assign o_status = r_status;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Bounded deque of signed 32-bit values held in a two-read-port RAM.
// On the accept edge the RAM is written and both ends are read; the sequencer then
// loads the result register once it is free. A new beat is not taken until the
// previous result has been loaded into the output register.
// The output register lets the next item enter while a result waits.
// Reset (sync, active low) empties the queue, clears the reverse flag, holds tready low.
module double_ended_queue_unit #(
    parameter int DEPTH  = deq_pkg::DEQ_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OUT_B = 2 * deq_pkg::VALUE_W + CW + 1 + deq_pkg::STATUS_W,
    localparam int OUT_W = ((OUT_B + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // mode[2:0], value[34:3]
    input  logic [deq_pkg::IN_W-1:0] i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // top_value, bottom_value, count, is_empty, status (lowest first)
    output logic [OUT_W-1:0]         o_m_axis_tdata
);

    import deq_pkg::*;

    t_deq_state          r_state, n_state;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic                w_accept, w_load;
    logic [VALUE_W-1:0]  w_top, w_bottom;
    logic [CW-1:0]       w_count;
    logic [STATUS_W-1:0] w_status;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    deq_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_mode   (i_s_axis_tdata[MODE_W-1:0]),
        .i_value  (i_s_axis_tdata[MODE_W+VALUE_W-1:MODE_W]),
        .o_top    (w_top),
        .o_bottom (w_bottom),
        .o_count  (w_count),
        .o_status (w_status)
    );

    // sequencer: take a beat, then hand the result to the output register
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_load          = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = i_rst_n;
                if (w_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                w_load = !r_out_valid || i_m_axis_tready;
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= OUT_W'({w_status, (w_count == '0), w_count, w_bottom, w_top});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/deq_checker.sv =====
`include "double_ended_queue_unit_assert.svh"

module deq_checker #(
    parameter int DEPTH  = deq_pkg::DEQ_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OUT_B = 2 * deq_pkg::VALUE_W + CW + 1 + deq_pkg::STATUS_W,
    localparam int OUT_W = ((OUT_B + 7) / 8) * 8
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_axis_tvalid,
    input logic                     o_s_axis_tready,
    input logic [deq_pkg::IN_W-1:0] i_s_axis_tdata,
    input logic                     o_m_axis_tvalid,
    input logic                     i_m_axis_tready,
    input logic [OUT_W-1:0]         o_m_axis_tdata
);

    import deq_pkg::*;

    localparam int CNT_LSB = 2 * VALUE_W;

    logic [2*VALUE_W-1:0] w_ends;
    logic [CW-1:0]        w_count;
    logic                 w_is_empty;
    logic [STATUS_W-1:0]  w_status;
    logic                 w_in_beat;

    assign w_ends     = o_m_axis_tdata[2*VALUE_W-1:0];
    assign w_count    = o_m_axis_tdata[CNT_LSB +: CW];
    assign w_is_empty = o_m_axis_tdata[CNT_LSB + CW];
    assign w_status   = o_m_axis_tdata[CNT_LSB + CW + 1 +: STATUS_W];
    assign w_in_beat  = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata != '1 || 1'b1);

    // stalled result beat holds
    `DEQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result beat changed while stalled")
    // empty flag agrees with the count
    `DEQ_ASSERT_IMP(a_empty_flag, i_clk, i_rst_n, o_m_axis_tvalid, w_is_empty == (w_count == '0), "empty flag disagrees with count")
    // empty queue reports zero ends
    `DEQ_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_m_axis_tvalid && w_is_empty, w_ends == '0, "nonzero end value on empty queue")
    // count within capacity and status a defined code
    `DEQ_ASSERT_IMP(a_count_range, i_clk, i_rst_n, o_m_axis_tvalid, (w_count <= CW'(DEPTH)) && (w_status <= STATUS_EMPTY), "count or status out of range")
    // one item in flight: input closes right after a beat
    `DEQ_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, w_in_beat, !o_s_axis_tready, "input ready right after an accepted beat")

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

// ===== bench/double_ended_queue_unit_tb.sv =====
module double_ended_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH      = DEQ_DEPTH;
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int OUT_B      = 2 * VALUE_W + CW + 1 + STATUS_W;
    localparam int OUT_W      = ((OUT_B + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 20;

    // codes outside the defined set; the block treats them as a query
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_op_mix;

    // one answer beat, unpacked
    typedef struct {
        logic signed [VALUE_W-1:0] top_value;
        logic signed [VALUE_W-1:0] bottom_value;
        logic [CW-1:0]             count;
        logic                      is_empty;
        logic [STATUS_W-1:0]       status;
    } t_deq_answer;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tready = 1'b0;
    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [OUT_W-1:0]  o_m_axis_tdata;

    // shadow deque
    logic [VALUE_W-1:0] shadow_slots [DEPTH];
    int                 shadow_front   = 0;
    int                 shadow_count   = 0;
    bit                 shadow_flipped = 1'b0;

    t_deq_answer pending_answers [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          rx_hold     = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;

    double_ended_queue_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // apply one request to the shadow deque and return the answer it yields
    function automatic t_deq_answer apply_deque_op(logic [MODE_W-1:0] mode,
                                                   logic [VALUE_W-1:0] value);
        t_deq_answer ans;
        bit          at_top;
        bit          top_is_high;
        bit          full;
        bit          empty;
        logic [VALUE_W-1:0] high_val;
        logic [VALUE_W-1:0] low_val;
        ans.status  = STATUS_DONE;
        full        = (shadow_count >= DEPTH);
        empty       = (shadow_count == 0);
        top_is_high = !shadow_flipped;
        case (mode)
            MODE_PUSH_TOP, MODE_PUSH_BOTTOM: begin
                at_top = (mode == MODE_PUSH_TOP);
                if (full) begin
                    ans.status = STATUS_FULL;
                end else if (at_top == top_is_high) begin
                    shadow_slots[(shadow_front + shadow_count) % DEPTH] = value;
                    shadow_count++;
                end else begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_slots[shadow_front] = value;
                    shadow_count++;
                end
            end
            MODE_POP_TOP, MODE_POP_BOTTOM: begin
                at_top = (mode == MODE_POP_TOP);
                if (empty) begin
                    ans.status = STATUS_EMPTY;
                end else if (at_top == top_is_high) begin
                    shadow_count--;
                end else begin
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            end
            MODE_REVERSE: begin
                shadow_flipped = !shadow_flipped;
            end
            default: begin
                if (empty) ans.status = STATUS_EMPTY;
            end
        endcase
        high_val = '0;
        low_val  = '0;
        if (shadow_count != 0) begin
            high_val = shadow_slots[(shadow_front + shadow_count - 1) % DEPTH];
            low_val  = shadow_slots[shadow_front];
        end
        ans.top_value    = shadow_flipped ? low_val : high_val;
        ans.bottom_value = shadow_flipped ? high_val : low_val;
        ans.count        = CW'(shadow_count);
        ans.is_empty     = (shadow_count == 0);
        return ans;
    endfunction

    // drive one request beat, predict its answer once taken, then maybe gap
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [VALUE_W-1:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - MODE_W - VALUE_W){1'b0}}, value, mode};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_answers.push_back(apply_deque_op(mode, value));
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(t_op_mix mix);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   begin push_pct = 70; pop_pct = 20; end
            MIX_SHRINK: begin push_pct = 20; pop_pct = 70; end
            default:    begin push_pct = 40; pop_pct = 40; end
        endcase
        if (r < push_pct)
            return $urandom_range(0, 1) ? MODE_PUSH_TOP : MODE_PUSH_BOTTOM;
        if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? MODE_POP_TOP : MODE_POP_BOTTOM;
        case ($urandom_range(0, 3))
            0, 1:    return MODE_REVERSE;
            2:       return MODE_QUERY;
            default: return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
        endcase
    endfunction

    // empty-queue requests, value extremes, every code, reverse in both states
    task automatic test_directed();
        send_request(MODE_QUERY, 32'h0);
        send_request(MODE_POP_TOP, 32'h0);
        send_request(MODE_POP_BOTTOM, 32'hffff_ffff);
        send_request(MODE_REVERSE, 32'h0);
        send_request(MODE_SPARE_LO, 32'h0);
        send_request(MODE_REVERSE, 32'h0);
        send_request(MODE_PUSH_TOP, 32'h7fff_ffff);
        send_request(MODE_PUSH_BOTTOM, 32'h8000_0000);
        send_request(MODE_PUSH_TOP, 32'h0000_0000);
        send_request(MODE_PUSH_BOTTOM, 32'hffff_ffff);
        send_request(MODE_QUERY, 32'h1234_5678);
        send_request(MODE_SPARE_LO, 32'h0);
        send_request(MODE_SPARE_HI, 32'hffff_ffff);
        send_request(MODE_REVERSE, 32'h0);
        send_request(MODE_PUSH_TOP, 32'h0000_0001);
        send_request(MODE_PUSH_BOTTOM, 32'hffff_fffe);
        send_request(MODE_POP_BOTTOM, 32'h0);
        send_request(MODE_POP_TOP, 32'h0);
        send_request(MODE_REVERSE, 32'h0);
        send_request(MODE_POP_TOP, 32'h0);
        send_request(MODE_POP_BOTTOM, 32'h0);
        send_request(MODE_POP_TOP, 32'h0);
        send_request(MODE_POP_BOTTOM, 32'h0);
        send_request(MODE_POP_TOP, 32'h0);
        send_request(MODE_SPARE_HI, 32'h0);
    endtask

    // fill to capacity, try refused pushes at both ends, then drain past empty
    task automatic test_full_and_drain();
        while (shadow_count < DEPTH)
            send_request($urandom_range(0, 1) ? MODE_PUSH_TOP : MODE_PUSH_BOTTOM,
                         pick_value());
        send_request(MODE_PUSH_TOP, 32'h7fff_ffff);
        send_request(MODE_PUSH_BOTTOM, 32'h8000_0000);
        send_request(MODE_REVERSE, 32'h0);
        send_request(MODE_QUERY, 32'h0);
        send_request(MODE_PUSH_TOP, $urandom);
        send_request(MODE_PUSH_BOTTOM, $urandom);
        while (shadow_count > 0)
            send_request($urandom_range(0, 1) ? MODE_POP_TOP : MODE_POP_BOTTOM,
                         $urandom);
        send_request(MODE_POP_TOP, 32'h0);
        send_request(MODE_POP_BOTTOM, 32'h0);
        send_request(MODE_QUERY, 32'h0);
        send_request(MODE_REVERSE, 32'h0);
    endtask

    // segments of random requests that push the depth up, down or sideways
    task automatic test_random_mix();
        t_op_mix mix;
        for (int seg = 0; seg < 10; seg++) begin
            case ($urandom_range(0, 2))
                0:       mix = MIX_GROW;
                1:       mix = MIX_SHRINK;
                default: mix = MIX_EVEN;
            endcase
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 95; n++)
                send_request(pick_mode(mix), pick_value());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // result side backpressure: random stall after each taken beat
    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && m_tready)
            rx_hold = rx_steady ? 0 : $urandom_range(0, 3);
        else if (rx_hold > 0)
            rx_hold--;
        m_tready <= (rx_hold == 0);
    end

    // compare each answer beat with the oldest prediction
    always @(posedge i_clk) begin
        t_deq_answer want;
        t_deq_answer got;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got.top_value    = o_m_axis_tdata[0 +: VALUE_W];
            got.bottom_value = o_m_axis_tdata[VALUE_W +: VALUE_W];
            got.count        = o_m_axis_tdata[2 * VALUE_W +: CW];
            got.is_empty     = o_m_axis_tdata[2 * VALUE_W + CW];
            got.status       = o_m_axis_tdata[2 * VALUE_W + CW + 1 +: STATUS_W];
            if (pending_answers.size() == 0) begin
                $error("answer beat with nothing pending");
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (got.top_value !== want.top_value) begin
                    $error("top_value: expected %0d, got %0d",
                           want.top_value, got.top_value);
                    error_count++;
                end
                if (got.bottom_value !== want.bottom_value) begin
                    $error("bottom_value: expected %0d, got %0d",
                           want.bottom_value, got.bottom_value);
                    error_count++;
                end
                if (got.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, got.count);
                    error_count++;
                end
                if (got.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d",
                           want.is_empty, got.is_empty);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("double_ended_queue_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_and_drain();
        test_random_mix();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (error_count == 0)
            $display("double_ended_queue_unit verification clean");
        else
            $display("double_ended_queue_unit verification failed");
        $finish;
    end

endmodule
